// ===== sv/trs_pkg.sv =====
// Shared widths, register indexes and defaults for the trapezoid ramp setpoint block.
`default_nettype none
package trs_pkg;

    localparam int POS_W      = 32;
    localparam int SPD_W      = 21;
    localparam int LIM_W      = 20;
    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIM_W;
    localparam int ERR_W      = POS_W + 1;
    localparam int SQ_W       = 2 * SPD_W - 1;
    localparam int DIVS_W     = REG_W + 1;
    localparam int PIV_W      = SQ_W + 2;
    localparam int VSUM_W     = SPD_W + 2;

    localparam int unsigned ARRIVAL_WINDOW_DEF = 16;

    localparam logic [LIM_W-1:0] SPEED_LIMIT_RST = LIM_W'(1000);
    localparam logic [REG_W-1:0] RAMP_RST        = REG_W'(10);
    localparam logic [REG_W-1:0] GAIN_RST        = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT_UP   = 3'd0,
        CFG_SPEED_LIMIT_DOWN = 3'd1,
        CFG_ACCEL_FORWARD    = 3'd2,
        CFG_DECEL_FORWARD    = 3'd3,
        CFG_ACCEL_REVERSE    = 3'd4,
        CFG_DECEL_REVERSE    = 3'd5,
        CFG_ANTICIP_FORWARD  = 3'd6,
        CFG_ANTICIP_REVERSE  = 3'd7
    } t_cfg_idx;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL_SQ   = 8'b0000_0010,
        S_MUL_GAIN = 8'b0000_0100,
        S_DIV      = 8'b0000_1000,
        S_SUM      = 8'b0001_0000,
        S_PIVOT    = 8'b0010_0000,
        S_STEP     = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

// ===== sv/trs_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module trs_div
    import trs_pkg::*;
#(
    parameter int N_W = SQ_W,
    parameter int D_W = DIVS_W
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_done,
    output logic [N_W-1:0]      o_quotient
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W:0]     rem_sh;
    logic             ge;
    logic [D_W:0]     diff;

    always_comb begin
        rem_sh = {r_rem, r_quo[N_W-1]};
        ge     = rem_sh >= {1'b0, r_div};
        diff   = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[N_W-2:0], ge};
            r_rem <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== sv/trapezoid_ramp_setpoint.sv =====
// Top level of the trapezoid ramp setpoint generator.
// One item in gives one result item out; no new item is taken before the
// cycle after the result is loaded into the output register. The 41-step
// bit-serial divider forms speed squared over twice the deceleration; a
// single 21x21 multiplier forms both the square and the anticipation term.
// A finished result waits in the output register while the next item is
// already being worked on. Configuration writes take effect at once and
// belong between items.
`default_nettype none
module trapezoid_ramp_setpoint
    import trs_pkg::*;
#(
    parameter int unsigned ARRIVAL_WINDOW = ARRIVAL_WINDOW_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [POS_W-1:0] i_target_position,
    input  wire logic signed [POS_W-1:0] i_measured_position,
    input  wire logic signed [SPD_W-1:0] i_measured_speed,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [POS_W-1:0]      o_position_setpoint,
    output logic signed [SPD_W-1:0]      o_speed_setpoint,
    output logic                         o_arrived
);

    logic [LIM_W-1:0] r_lim_up;
    logic [LIM_W-1:0] r_lim_down;
    logic [REG_W-1:0] r_acc_f;
    logic [REG_W-1:0] r_dec_f;
    logic [REG_W-1:0] r_acc_r;
    logic [REG_W-1:0] r_dec_r;
    logic [REG_W-1:0] r_ant_f;
    logic [REG_W-1:0] r_ant_r;

    t_state r_state;
    t_state n_state;

    logic signed [POS_W-1:0] r_target;
    logic signed [POS_W-1:0] r_pos;
    logic signed [ERR_W-1:0] r_err;
    logic [SPD_W-1:0]        r_aspd;
    logic                    r_spd_neg;
    logic                    r_arrive;
    logic [SQ_W-1:0]         r_prod;
    logic [SQ_W-1:0]         r_dist;
    logic                    r_up;
    logic signed [SPD_W-1:0] r_v;
    logic signed [SPD_W-1:0] r_last;

    logic                    r_o_valid;
    logic signed [POS_W-1:0] r_o_pos;
    logic signed [SPD_W-1:0] r_o_spd;
    logic                    r_o_arr;

    logic                    in_acc;
    logic                    out_free;
    logic                    fwd;
    logic [SPD_W-1:0]        mul_b;
    logic [2*SPD_W-1:0]      mul_full;
    logic [REG_W-1:0]        decel_sel;
    logic [REG_W-1:0]        decel_eff;
    logic [REG_W-1:0]        gain_sel;
    logic [ERR_W-1:0]        aerr;
    logic signed [PIV_W-1:0] pivot;
    logic [REG_W-1:0]        step_mag;
    logic signed [VSUM_W-1:0] vsum;
    logic signed [VSUM_W-1:0] vlo;
    logic signed [VSUM_W-1:0] vhi;
    logic signed [VSUM_W-1:0] vclamp;
    logic signed [ERR_W-1:0] psum;
    logic signed [POS_W-1:0] psat;
    logic                    div_start;
    logic                    div_done;
    logic [SQ_W-1:0]         div_quo;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign fwd      = !r_err[ERR_W-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_up   <= SPEED_LIMIT_RST;
            r_lim_down <= SPEED_LIMIT_RST;
            r_acc_f    <= RAMP_RST;
            r_dec_f    <= RAMP_RST;
            r_acc_r    <= RAMP_RST;
            r_dec_r    <= RAMP_RST;
            r_ant_f    <= GAIN_RST;
            r_ant_r    <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_LIMIT_UP:   r_lim_up   <= i_cfg_data;
                CFG_SPEED_LIMIT_DOWN: r_lim_down <= i_cfg_data;
                CFG_ACCEL_FORWARD:    r_acc_f    <= i_cfg_data[REG_W-1:0];
                CFG_DECEL_FORWARD:    r_dec_f    <= i_cfg_data[REG_W-1:0];
                CFG_ACCEL_REVERSE:    r_acc_r    <= i_cfg_data[REG_W-1:0];
                CFG_DECEL_REVERSE:    r_dec_r    <= i_cfg_data[REG_W-1:0];
                CFG_ANTICIP_FORWARD:  r_ant_f    <= i_cfg_data[REG_W-1:0];
                CFG_ANTICIP_REVERSE:  r_ant_r    <= i_cfg_data[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier and datapath helpers
    always_comb begin
        decel_sel = fwd ? r_dec_f : r_dec_r;
        decel_eff = (decel_sel == '0) ? REG_W'(1) : decel_sel;
        gain_sel  = fwd ? r_ant_f : r_ant_r;
        mul_b     = (r_state == S_MUL_SQ) ? r_aspd : SPD_W'(gain_sel);
        mul_full  = r_aspd * mul_b;
        aerr      = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);

        pivot = r_spd_neg ? (PIV_W'(r_target) + $signed({2'b00, r_dist}))
                          : (PIV_W'(r_target) - $signed({2'b00, r_dist}));

        if (fwd) begin
            step_mag = r_up ? r_acc_f : r_dec_f;
        end else begin
            step_mag = r_up ? r_dec_r : r_acc_r;
        end
        vsum = r_up ? (VSUM_W'(r_last) + $signed(VSUM_W'(step_mag)))
                    : (VSUM_W'(r_last) - $signed(VSUM_W'(step_mag)));
        vlo  = -$signed(VSUM_W'(r_lim_down));
        vhi  = $signed(VSUM_W'(r_lim_up));
        priority if (vsum < vlo) begin
            vclamp = vlo;
        end else if (vsum > vhi) begin
            vclamp = vhi;
        end else begin
            vclamp = vsum;
        end

        psum = ERR_W'(r_pos) + ERR_W'(r_v);
        if (psum[ERR_W-1] != psum[ERR_W-2]) begin
            psat = psum[ERR_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            psat = psum[POS_W-1:0];
        end
    end

    assign div_start = (r_state == S_MUL_GAIN);

    trs_div #(
        .N_W (SQ_W),
        .D_W (DIVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  ({decel_eff, 1'b0}),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = S_MUL_SQ;
            S_MUL_SQ:   n_state = S_MUL_GAIN;
            S_MUL_GAIN: n_state = S_DIV;
            S_DIV:      if (div_done) n_state = S_SUM;
            S_SUM:      n_state = S_PIVOT;
            S_PIVOT:    n_state = S_STEP;
            S_STEP:     n_state = S_FIN;
            S_FIN:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN) && out_free) begin
                r_last <= r_arrive ? '0 : r_v;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_target  <= i_target_position;
            r_pos     <= i_measured_position;
            r_err     <= ERR_W'(i_target_position) - ERR_W'(i_measured_position);
            r_spd_neg <= i_measured_speed[SPD_W-1];
            r_aspd    <= i_measured_speed[SPD_W-1] ? SPD_W'(-i_measured_speed)
                                                   : SPD_W'(i_measured_speed);
        end
        if (r_state == S_MUL_SQ) begin
            r_arrive <= aerr < ERR_W'(ARRIVAL_WINDOW);
        end
        if ((r_state == S_MUL_SQ) || (r_state == S_MUL_GAIN)) begin
            r_prod <= mul_full[SQ_W-1:0];
        end
        if (r_state == S_SUM) begin
            r_dist <= div_quo + r_prod;
        end
        if (r_state == S_PIVOT) begin
            r_up <= pivot >= PIV_W'(r_pos);
        end
        if (r_state == S_STEP) begin
            r_v <= vclamp[SPD_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_o_pos <= r_arrive ? r_target : psat;
            r_o_spd <= r_arrive ? '0 : r_v;
            r_o_arr <= r_arrive;
        end
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_o_valid;
    assign o_position_setpoint = r_o_pos;
    assign o_speed_setpoint    = r_o_spd;
    assign o_arrived           = r_o_arr;

endmodule
`default_nettype wire

// ===== sv/trs_chk.sv =====
// Port-level checker for the trapezoid ramp setpoint block, with its bind.
`default_nettype none
module trs_chk
    import trs_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input wire logic                    i_valid,
    input wire logic                    o_ready,
    input wire logic signed [POS_W-1:0] i_target_position,
    input wire logic signed [POS_W-1:0] i_measured_position,
    input wire logic signed [SPD_W-1:0] i_measured_speed,
    input wire logic                    o_valid,
    input wire logic                    i_ready,
    input wire logic signed [POS_W-1:0] o_position_setpoint,
    input wire logic signed [SPD_W-1:0] o_speed_setpoint,
    input wire logic                    o_arrived
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position_setpoint)
            && $stable(o_speed_setpoint) && $stable(o_arrived))
        else $error("result item changed while stalled");

    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_arrived |-> o_speed_setpoint == '0)
        else $error("arrival with non-zero speed setpoint");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready again straight after an item was taken");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind trapezoid_ramp_setpoint trs_chk u_trs_chk (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the trapezoid ramp setpoint generator.
module tb;
    import trs_pkg::*;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};
    localparam int N_RANDOM     = 700;
    localparam int N_PHASES     = 7;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_sp;
        logic signed [SPD_W-1:0] spd_sp;
        logic                    arrived;
    } setpoint_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    typedef struct {
        row_kind_e               kind;
        bit                      typed;
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [POS_W-1:0] tgt;
        logic signed [POS_W-1:0] pos;
        logic signed [SPD_W-1:0] spd;
        setpoint_t               want;
    } tick_row_t;

    logic                    i_clk               = 1'b0;
    logic                    i_rst_n             = 1'b0;
    logic                    i_cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx           = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data          = '0;
    logic                    i_valid             = 1'b0;
    logic                    o_ready;
    logic signed [POS_W-1:0] i_target_position   = '0;
    logic signed [POS_W-1:0] i_measured_position = '0;
    logic signed [SPD_W-1:0] i_measured_speed    = '0;
    logic                    o_valid;
    logic                    i_ready             = 1'b0;
    logic signed [POS_W-1:0] o_position_setpoint;
    logic signed [SPD_W-1:0] o_speed_setpoint;
    logic                    o_arrived;

    logic [LIM_W-1:0]        lim_up    = SPEED_LIMIT_RST;
    logic [LIM_W-1:0]        lim_down  = SPEED_LIMIT_RST;
    logic [REG_W-1:0]        acc_fwd   = RAMP_RST;
    logic [REG_W-1:0]        dec_fwd   = RAMP_RST;
    logic [REG_W-1:0]        acc_rev   = RAMP_RST;
    logic [REG_W-1:0]        dec_rev   = RAMP_RST;
    logic [REG_W-1:0]        ant_fwd   = GAIN_RST;
    logic [REG_W-1:0]        ant_rev   = GAIN_RST;
    logic signed [SPD_W-1:0] speed_mem = '0;
    setpoint_t               last_sp   = '0;
    setpoint_t               setpoint_q[$];
    int                      fail_count    = 0;
    int                      send_idle_pct = 14;
    int                      rcv_idle_pct  = 62;

    trapezoid_ramp_setpoint dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_target_position   (i_target_position),
        .i_measured_position (i_measured_position),
        .i_measured_speed    (i_measured_speed),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_position_setpoint (o_position_setpoint),
        .o_speed_setpoint    (o_speed_setpoint),
        .o_arrived           (o_arrived)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic signed [POS_W-1:0] sat_pos(input longint x);
        if (x > longint'(POS_MAX)) return POS_MAX;
        if (x < longint'(POS_MIN)) return POS_MIN;
        return POS_W'(x);
    endfunction

    function automatic logic signed [SPD_W-1:0] sat_spd(input longint x);
        if (x > longint'(SPD_MAX)) return SPD_MAX;
        if (x < longint'(SPD_MIN)) return SPD_MIN;
        return SPD_W'(x);
    endfunction

    function automatic logic signed [POS_W-1:0] corner_pos();
        case ($urandom_range(3))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic setpoint_t ramp_predict(input logic signed [POS_W-1:0] tgt,
                                               input logic signed [POS_W-1:0] pos,
                                               input logic signed [SPD_W-1:0] spd);
        setpoint_t res;
        longint    err;
        longint    divisor;
        longint    gain;
        longint    aspd;
        longint    brake_len;
        longint    pivot;
        longint    step;
        longint    v;
        bit        fwd;
        err     = longint'(tgt) - longint'(pos);
        fwd     = (err >= 0);
        divisor = fwd ? longint'(dec_fwd) : longint'(dec_rev);
        gain    = fwd ? longint'(ant_fwd) : longint'(ant_rev);
        if (divisor == 0) divisor = 1;
        aspd      = (spd < 0) ? -longint'(spd) : longint'(spd);
        brake_len = (aspd * aspd) / (2 * divisor) + aspd * gain;
        pivot     = (spd >= 0) ? longint'(tgt) - brake_len : longint'(tgt) + brake_len;
        if (pivot >= longint'(pos)) begin
            step = fwd ? longint'(acc_fwd) : longint'(dec_rev);
        end else begin
            step = fwd ? -longint'(dec_fwd) : -longint'(acc_rev);
        end
        v = longint'(speed_mem) + step;
        if (v < -longint'(lim_down)) begin
            v = -longint'(lim_down);
        end else if (v > longint'(lim_up)) begin
            v = longint'(lim_up);
        end
        speed_mem = SPD_W'(v);
        if (((err < 0) ? -err : err) < longint'(ARRIVAL_WINDOW_DEF)) begin
            speed_mem   = '0;
            res.pos_sp  = tgt;
            res.spd_sp  = '0;
            res.arrived = 1'b1;
        end else begin
            res.pos_sp  = sat_pos(longint'(pos) + v);
            res.spd_sp  = SPD_W'(v);
            res.arrived = 1'b0;
        end
        return res;
    endfunction

    function automatic tick_row_t tick_row(input logic signed [POS_W-1:0] tgt,
                                           input logic signed [POS_W-1:0] pos,
                                           input logic signed [SPD_W-1:0] spd);
        tick_row_t r;
        r.kind  = ROW_ITEM;
        r.typed = 1'b0;
        r.idx   = CFG_SPEED_LIMIT_UP;
        r.data  = '0;
        r.tgt   = tgt;
        r.pos   = pos;
        r.spd   = spd;
        r.want  = '0;
        return r;
    endfunction

    function automatic tick_row_t known_row(input logic signed [POS_W-1:0] tgt,
                                            input logic signed [POS_W-1:0] pos,
                                            input logic signed [SPD_W-1:0] spd,
                                            input logic signed [POS_W-1:0] e_pos,
                                            input logic signed [SPD_W-1:0] e_spd,
                                            input logic                    e_arr);
        tick_row_t r;
        r              = tick_row(tgt, pos, spd);
        r.typed        = 1'b1;
        r.want.pos_sp  = e_pos;
        r.want.spd_sp  = e_spd;
        r.want.arrived = e_arr;
        return r;
    endfunction

    function automatic tick_row_t cfg_row(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        tick_row_t r;
        r      = tick_row('0, '0, '0);
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Drop valid and hold until every result item is back.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (setpoint_q.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SPEED_LIMIT_UP:   lim_up   = data[LIM_W-1:0];
            CFG_SPEED_LIMIT_DOWN: lim_down = data[LIM_W-1:0];
            CFG_ACCEL_FORWARD:    acc_fwd  = data[REG_W-1:0];
            CFG_DECEL_FORWARD:    dec_fwd  = data[REG_W-1:0];
            CFG_ACCEL_REVERSE:    acc_rev  = data[REG_W-1:0];
            CFG_DECEL_REVERSE:    dec_rev  = data[REG_W-1:0];
            CFG_ANTICIP_FORWARD:  ant_fwd  = data[REG_W-1:0];
            CFG_ANTICIP_REVERSE:  ant_rev  = data[REG_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic feed_tick(input tick_row_t row);
        setpoint_t got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_target_position   <= row.tgt;
        i_measured_position <= row.pos;
        i_measured_speed    <= row.spd;
        do @(posedge i_clk); while (!o_ready);
        got     = ramp_predict(row.tgt, row.pos, row.spd);
        last_sp = got;
        setpoint_q.push_back(row.typed ? row.want : got);
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        setpoint_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (setpoint_q.size() == 0) begin
                $error("result item with no expectation waiting");
                fail_count++;
            end else begin
                want = setpoint_q.pop_front();
                if (o_position_setpoint !== want.pos_sp) begin
                    $error("position_setpoint: expected %0d, got %0d",
                           $signed(want.pos_sp), o_position_setpoint);
                    fail_count++;
                end
                if (o_speed_setpoint !== want.spd_sp) begin
                    $error("speed_setpoint: expected %0d, got %0d",
                           $signed(want.spd_sp), o_speed_setpoint);
                    fail_count++;
                end
                if (o_arrived !== want.arrived) begin
                    $error("arrived: expected %0d, got %0d", want.arrived, o_arrived);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        tick_row_t               rows[$];
        tick_row_t               row;
        logic [CFG_DATA_W-1:0]   cfg_val [8];
        t_cfg_idx                idx;
        longint                  goal;
        longint                  span;
        longint                  jit;
        logic signed [POS_W-1:0] pos;
        int                      steps_left;

        steps_left = 0;
        goal       = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(known_row(0, 0, 0, 0, 0, 1'b1));
        rows.push_back(known_row(100, 0, 0, 10, 10, 1'b0));
        rows.push_back(known_row(15, 0, 0, 15, 0, 1'b1));
        rows.push_back(known_row(16, 0, 0, 10, 10, 1'b0));
        rows.push_back(known_row(-15, 0, 0, -15, 0, 1'b1));
        rows.push_back(known_row(-16, 0, 0, -10, -10, 1'b0));
        rows.push_back(known_row(POS_MAX, POS_MAX, 0, POS_MAX, 0, 1'b1));
        rows.push_back(known_row(POS_MIN, POS_MIN, SPD_MIN, POS_MIN, 0, 1'b1));
        rows.push_back(tick_row(POS_MAX, POS_MIN, 0));
        rows.push_back(tick_row(POS_MIN, POS_MAX, 0));
        rows.push_back(tick_row(1000000, 0, SPD_MAX));
        rows.push_back(tick_row(-1000000, 0, SPD_MIN));
        rows.push_back(tick_row(1000000, 0, SPD_MIN));
        rows.push_back(tick_row(-1000000, 0, SPD_MAX));
        rows.push_back(cfg_row(CFG_SPEED_LIMIT_UP, 20'hFFFFF));
        rows.push_back(cfg_row(CFG_ACCEL_FORWARD, 20'hFFFFF));
        rows.push_back(tick_row(POS_MAX, POS_MAX - 50000, 0));
        rows.push_back(tick_row(POS_MAX, POS_MAX - 50000, 0));
        rows.push_back(cfg_row(CFG_SPEED_LIMIT_DOWN, 20'hFFFFF));
        rows.push_back(cfg_row(CFG_DECEL_FORWARD, 20'h5FFFF));
        rows.push_back(tick_row(POS_MIN + 40, POS_MIN, SPD_MAX));
        rows.push_back(tick_row(POS_MIN + 40, POS_MIN, SPD_MAX));
        rows.push_back(cfg_row(CFG_DECEL_FORWARD, 20'h00000));
        rows.push_back(cfg_row(CFG_DECEL_REVERSE, 20'hF0000));
        rows.push_back(tick_row(1000, 0, 30));
        rows.push_back(tick_row(-1000, 0, -30));
        rows.push_back(tick_row(-1000, 0, SPD_MAX));
        rows.push_back(cfg_row(CFG_ANTICIP_FORWARD, 20'h0FFFF));
        rows.push_back(cfg_row(CFG_ANTICIP_REVERSE, 20'hAFFFF));
        rows.push_back(cfg_row(CFG_ACCEL_REVERSE, 20'h00003));
        rows.push_back(tick_row(2000000, 0, 100));
        rows.push_back(tick_row(-2000000, 0, -100));
        rows.push_back(tick_row(5, 0, -7));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                feed_tick(rows[i]);
            end
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % (N_RANDOM / N_PHASES) == 0) begin
                case (k / (N_RANDOM / N_PHASES))
                    0: foreach (cfg_val[i]) cfg_val[i] = 20'hFFFFF;
                    1: foreach (cfg_val[i]) cfg_val[i] = 20'h00000;
                    3: foreach (cfg_val[i]) cfg_val[i] = CFG_DATA_W'($urandom);
                    4: begin
                        cfg_val[CFG_SPEED_LIMIT_UP]   = CFG_DATA_W'($urandom_range(50000, 1048575));
                        cfg_val[CFG_SPEED_LIMIT_DOWN] = CFG_DATA_W'($urandom_range(1, 300));
                        cfg_val[CFG_ACCEL_FORWARD]    = CFG_DATA_W'($urandom_range(1000, 65535));
                        cfg_val[CFG_DECEL_FORWARD]    = CFG_DATA_W'($urandom_range(1, 20));
                        cfg_val[CFG_ACCEL_REVERSE]    = CFG_DATA_W'($urandom_range(1, 20));
                        cfg_val[CFG_DECEL_REVERSE]    = CFG_DATA_W'($urandom_range(1000, 65535));
                        cfg_val[CFG_ANTICIP_FORWARD]  = CFG_DATA_W'($urandom_range(0, 1));
                        cfg_val[CFG_ANTICIP_REVERSE]  = CFG_DATA_W'($urandom_range(0, 1));
                    end
                    6: begin
                        cfg_val[CFG_SPEED_LIMIT_UP]   = CFG_DATA_W'($urandom_range(2000, 20000));
                        cfg_val[CFG_SPEED_LIMIT_DOWN] = CFG_DATA_W'($urandom_range(2000, 20000));
                        cfg_val[CFG_ACCEL_FORWARD]    = CFG_DATA_W'($urandom_range(1, 50));
                        cfg_val[CFG_DECEL_FORWARD]    = CFG_DATA_W'(1);
                        cfg_val[CFG_ACCEL_REVERSE]    = CFG_DATA_W'($urandom_range(1, 50));
                        cfg_val[CFG_DECEL_REVERSE]    = CFG_DATA_W'($urandom_range(1, 50));
                        cfg_val[CFG_ANTICIP_FORWARD]  = CFG_DATA_W'($urandom_range(1000, 65535));
                        cfg_val[CFG_ANTICIP_REVERSE]  = CFG_DATA_W'($urandom_range(1000, 65535));
                    end
                    default: begin
                        cfg_val[CFG_SPEED_LIMIT_UP]   = CFG_DATA_W'($urandom_range(100, 5000));
                        cfg_val[CFG_SPEED_LIMIT_DOWN] = CFG_DATA_W'($urandom_range(100, 5000));
                        cfg_val[CFG_ACCEL_FORWARD]    = {4'($urandom), 16'($urandom_range(1, 200))};
                        cfg_val[CFG_DECEL_FORWARD]    = {4'($urandom), 16'($urandom_range(1, 200))};
                        cfg_val[CFG_ACCEL_REVERSE]    = {4'($urandom), 16'($urandom_range(1, 200))};
                        cfg_val[CFG_DECEL_REVERSE]    = {4'($urandom), 16'($urandom_range(1, 200))};
                        cfg_val[CFG_ANTICIP_FORWARD]  = {4'($urandom), 16'($urandom_range(0, 3))};
                        cfg_val[CFG_ANTICIP_REVERSE]  = {4'($urandom), 16'($urandom_range(0, 3))};
                    end
                endcase
                idx = idx.first();
                repeat (idx.num()) begin
                    write_reg(idx, cfg_val[idx]);
                    idx = idx.next();
                end
            end

            case (k * 3 / N_RANDOM)
                0: begin
                    send_idle_pct = 14;
                    rcv_idle_pct  = 62;
                end
                1: begin
                    send_idle_pct = 62;
                    rcv_idle_pct  = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                end
            endcase

            if ($urandom_range(99) < 25) begin
                case ($urandom_range(3))
                    0: row = tick_row($urandom, $urandom, SPD_W'($urandom));
                    1: begin
                        pos = $urandom;
                        jit = longint'($urandom_range(0, 80)) - 40;
                        row = tick_row(sat_pos(longint'(pos) + jit), pos, SPD_W'($urandom));
                    end
                    2: row = tick_row(corner_pos(), corner_pos(),
                                      $urandom_range(1) ? SPD_MAX : SPD_MIN);
                    default: row = tick_row($urandom, $urandom,
                                            sat_spd(longint'($urandom_range(0, 2000)) - 1000));
                endcase
            end else begin
                // follow the last setpoint towards a goal, retarget on arrival or when the steps run out
                if (steps_left == 0 || last_sp.arrived) begin
                    steps_left = $urandom_range(20, 150);
                    case ($urandom_range(3))
                        0: span = $urandom_range(0, 40);
                        1: span = $urandom_range(40, 2000);
                        2: span = $urandom_range(2000, 200000);
                        default: span = $urandom_range(200000, 1 << 30);
                    endcase
                    if ($urandom_range(1)) span = -span;
                    goal = longint'(last_sp.pos_sp) + span;
                end
                steps_left--;
                jit = longint'($urandom_range(0, 6)) - 3;
                pos = sat_pos(longint'(last_sp.pos_sp) + jit);
                jit = longint'($urandom_range(0, 6)) - 3;
                row = tick_row(sat_pos(goal), pos, sat_spd(longint'(last_sp.spd_sp) + jit));
            end
            feed_tick(row);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
